// File: hdl/tvcc_pkg.sv
// Types, register indexes and helpers shared by the viewport chunk clipper.
package tvcc_pkg;

  typedef enum logic [1:0] {
    SLOT_CUR  = 2'd0,
    SLOT_HORZ = 2'd1,
    SLOT_VERT = 2'd2,
    SLOT_DIAG = 2'd3
  } slot_e;

  localparam logic [2:0] CFG_WIN_COLS    = 3'd0;
  localparam logic [2:0] CFG_WIN_ROWS    = 3'd1;
  localparam logic [2:0] CFG_PLR_COL     = 3'd2;
  localparam logic [2:0] CFG_PLR_ROW     = 3'd3;
  localparam logic [2:0] CFG_PLR_RIGHT   = 3'd4;
  localparam logic [2:0] CFG_PLR_BELOW   = 3'd5;
  localparam logic [2:0] CFG_CHUNK_COLS  = 3'd6;
  localparam logic [2:0] CFG_CHUNK_ROWS  = 3'd7;

  localparam logic [7:0] RST_WIN_COLS   = 8'd20;
  localparam logic [7:0] RST_WIN_ROWS   = 8'd15;
  localparam logic [7:0] RST_PLR_COL    = 8'd10;
  localparam logic [7:0] RST_PLR_ROW    = 8'd7;
  localparam logic [7:0] RST_PLR_RIGHT  = 8'd9;
  localparam logic [7:0] RST_PLR_BELOW  = 8'd7;
  localparam logic [7:0] RST_CHUNK_COLS = 8'd32;
  localparam logic [7:0] RST_CHUNK_ROWS = 8'd32;

  // split of one axis over the current chunk and its neighbor on that axis
  typedef struct packed {
    logic        neg;     // overflow toward lower coordinates
    logic        pos;     // overflow toward higher coordinates
    logic [15:0] pos0;    // pixel origin in the current chunk
    logic [15:0] pos1;    // pixel origin in the neighbor
    logic [8:0]  span0;   // clamped tiles in the current chunk
    logic [8:0]  span1;   // clamped tiles in the neighbor
    logic [7:0]  start0;
    logic [7:0]  start1;
    logic [15:0] coord1;  // neighbor chunk coordinate
  } axis_t;

  typedef struct packed {
    logic        present;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [8:0]  span_columns;
    logic [8:0]  span_rows;
    logic [7:0]  start_column;
    logic [7:0]  start_row;
    logic [15:0] chunk_x;
    logic [15:0] chunk_y;
  } res_t;

  function automatic logic grid_has(logic [8:0] bits, logic signed [3:0] x,
                                    logic signed [3:0] y);
    logic [3:0] idx;
    idx = 4'(x[1:0]) * 4'd3 + 4'(y[1:0]);
    if (x < 4'sd0 || x > 4'sd2 || y < 4'sd0 || y > 4'sd2) begin
      return 1'b0;
    end
    return bits[idx];
  endfunction

endpackage

// File: hdl/tvcc_axis.sv
// Splits one axis of the bordered window over the current chunk and one neighbor.
module tvcc_axis
  import tvcc_pkg::*;
#(
  parameter int unsigned TILE_SIZE = 32
) (
  input  logic [7:0]  rel_i,
  input  logic [7:0]  before_i,
  input  logic [7:0]  after_i,
  input  logic [7:0]  window_i,
  input  logic [7:0]  chunk_i,
  input  logic [15:0] coord_i,
  output axis_t       axis_o
);

  localparam logic [15:0] ZeroPx = 16'(-2 * $signed(TILE_SIZE));
  localparam logic [15:0] TilePx = 16'(TILE_SIZE);

  logic signed [10:0] e;
  logic signed [10:0] room;
  logic signed [10:0] lim;
  logic [10:0]        negw;
  logic [10:0]        dw;
  logic [8:0]         neg;
  logic [8:0]         d;
  logic [8:0]         full;
  logic [8:0]         chunk9;
  logic [8:0]         span0;
  logic [8:0]         span1;
  logic               is_neg;
  logic               over;

  always_comb begin
    e      = $signed({3'b000, rel_i}) - $signed({3'b000, before_i}) - 11'sd2;
    room   = $signed({3'b000, chunk_i}) - $signed({3'b000, rel_i}) - 11'sd1;
    lim    = $signed({3'b000, after_i}) + 11'sd2;
    negw   = 11'(-e);
    dw     = 11'(lim - room);
    neg    = negw[8:0];
    // saturated: every use is clamped well below 511
    d      = (dw > 11'd511) ? 9'h1ff : dw[8:0];
    full   = {1'b0, window_i} + 9'd4;
    chunk9 = {1'b0, chunk_i};
    is_neg = e < 11'sd0;
    over   = !is_neg && (room < lim);

    axis_o        = '0;
    axis_o.neg    = is_neg;
    axis_o.pos    = over;
    axis_o.coord1 = coord_i;
    span0         = full;
    span1         = '0;
    axis_o.pos0   = ZeroPx;
    if (is_neg) begin
      span0         = (full > neg) ? full - neg : 9'd0;
      span1         = neg;
      axis_o.pos0   = ZeroPx + TilePx * {7'd0, neg};
      axis_o.pos1   = ZeroPx;
      axis_o.start0 = '0;
      axis_o.start1 = (chunk9 > neg) ? 8'(chunk9 - neg) : 8'd0;
      axis_o.coord1 = coord_i - 16'd1;
    end else begin
      axis_o.start0 = e[7:0];
      if (over) begin
        span0         = (full > d) ? full - d : 9'd0;
        span1         = d;
        axis_o.pos1   = ZeroPx + TilePx * {7'd0, span0};
        axis_o.coord1 = coord_i + 16'd1;
      end
    end
    axis_o.span0 = (span0 > chunk9) ? chunk9 : span0;
    axis_o.span1 = (span1 > chunk9) ? chunk9 : span1;
  end

endmodule

// File: hdl/tvcc_emit.sv
// Result buffer holding the four slot results of one item, sent one beat per cycle.
module tvcc_emit
  import tvcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t [3:0] item_i,
  output logic       free_o,
  output logic       valid_o,
  output slot_e      slot_o,
  output res_t       res_o
);

  res_t [3:0] ent_q;
  logic       vld_q, vld_d;
  slot_e      cnt_q, cnt_d;

  assign free_o  = !vld_q || (cnt_q == SLOT_DIAG);
  assign valid_o = vld_q;
  assign slot_o  = cnt_q;
  assign res_o   = ent_q[cnt_q];

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (load_i) begin
      vld_d = 1'b1;
      cnt_d = SLOT_CUR;
    end else if (vld_q) begin
      vld_d = (cnt_q != SLOT_DIAG);
      cnt_d = slot_e'(cnt_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= SLOT_CUR;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= item_i;
    end
  end

endmodule

// File: hdl/tile_viewport_chunk_clipper_top.sv
// Top level of the viewport chunk clipper: registers, input stage and slot assembly.
//
// Use: write the eight 8-bit geometry registers through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; each write lands at the clock edge that sees cfg_we_i high.
// An item (viewer position in the chunk, grid focus, chunk coordinates, presence
// bits) is taken at an edge where start_i is high and busy_o low. It goes into an
// input register; the next edge with a free buffer moves the split of both axes into
// a four-entry result buffer. The buffer then drives one beat per cycle with valid_o
// high, slots current, horizontal, vertical, diagonal in order, last_o on the diagonal.
// Slot 0 reaches the ports once the item has passed the input register into the result
// buffer; while the previous item's beats finish, the item waits in the input register.
// The next item is taken while the previous one's beats still go out, so back to back
// items give an unbroken stream of beats.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// Reset clears the input and buffer valid flags and loads the register defaults
// (20x15 window, viewer at 10/7 with 9/7 beyond, 32x32 chunks).
module tile_viewport_chunk_clipper_top
  import tvcc_pkg::*;
#(
  parameter int unsigned TILE_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  rel_column_i,
  input  logic [7:0]  rel_row_i,
  input  logic [1:0]  focus_x_i,
  input  logic [1:0]  focus_y_i,
  input  logic signed [15:0] chunk_x_i,
  input  logic signed [15:0] chunk_y_i,
  input  logic [8:0]  neighbor_present_i,
  output logic        valid_o,
  output logic [1:0]  slot_o,
  output logic        present_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic [8:0]  span_columns_o,
  output logic [8:0]  span_rows_o,
  output logic [7:0]  start_column_o,
  output logic [7:0]  start_row_o,
  output logic signed [15:0] out_chunk_x_o,
  output logic signed [15:0] out_chunk_y_o,
  output logic        last_o
);

  logic [7:0] win_cols_q, win_rows_q, plr_col_q, plr_row_q;
  logic [7:0] plr_right_q, plr_below_q, chunk_cols_q, chunk_rows_q;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  rel_col_q, rel_row_q;
  logic [1:0]  fx_q, fy_q;
  logic [15:0] cx_q, cy_q;
  logic [8:0]  bits_q;

  logic       accept;
  logic       buf_free;
  logic       move;
  axis_t      ax, ay;
  res_t [3:0] item;
  res_t       res;
  slot_e      slot;
  logic signed [3:0] hx, vy, fxs, fys;
  logic       p1, p2, p3;

  assign accept = start_i && !busy_o;
  assign move   = in_vld_q && buf_free;
  assign busy_o = in_vld_q && !buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cols_q   <= RST_WIN_COLS;
      win_rows_q   <= RST_WIN_ROWS;
      plr_col_q    <= RST_PLR_COL;
      plr_row_q    <= RST_PLR_ROW;
      plr_right_q  <= RST_PLR_RIGHT;
      plr_below_q  <= RST_PLR_BELOW;
      chunk_cols_q <= RST_CHUNK_COLS;
      chunk_rows_q <= RST_CHUNK_ROWS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIN_COLS:   win_cols_q   <= cfg_data_i;
        CFG_WIN_ROWS:   win_rows_q   <= cfg_data_i;
        CFG_PLR_COL:    plr_col_q    <= cfg_data_i;
        CFG_PLR_ROW:    plr_row_q    <= cfg_data_i;
        CFG_PLR_RIGHT:  plr_right_q  <= cfg_data_i;
        CFG_PLR_BELOW:  plr_below_q  <= cfg_data_i;
        CFG_CHUNK_COLS: chunk_cols_q <= cfg_data_i;
        CFG_CHUNK_ROWS: chunk_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rel_col_q <= rel_column_i;
      rel_row_q <= rel_row_i;
      fx_q      <= focus_x_i;
      fy_q      <= focus_y_i;
      cx_q      <= chunk_x_i;
      cy_q      <= chunk_y_i;
      bits_q    <= neighbor_present_i;
    end
  end

  tvcc_axis #(.TILE_SIZE(TILE_SIZE)) u_axis_x (
    .rel_i    (rel_col_q),
    .before_i (plr_col_q),
    .after_i  (plr_right_q),
    .window_i (win_cols_q),
    .chunk_i  (chunk_cols_q),
    .coord_i  (cx_q),
    .axis_o   (ax)
  );

  tvcc_axis #(.TILE_SIZE(TILE_SIZE)) u_axis_y (
    .rel_i    (rel_row_q),
    .before_i (plr_row_q),
    .after_i  (plr_below_q),
    .window_i (win_rows_q),
    .chunk_i  (chunk_rows_q),
    .coord_i  (cy_q),
    .axis_o   (ay)
  );

  always_comb begin
    fxs = $signed({2'b00, fx_q});
    fys = $signed({2'b00, fy_q});
    hx  = ax.neg ? fxs - 4'sd1 : (ax.pos ? fxs + 4'sd1 : fxs);
    vy  = ay.neg ? fys - 4'sd1 : (ay.pos ? fys + 4'sd1 : fys);
    p1  = (ax.neg || ax.pos) && grid_has(bits_q, hx, fys);
    p2  = (ay.neg || ay.pos) && grid_has(bits_q, fxs, vy);
    p3  = (ax.neg || ax.pos) && (ay.neg || ay.pos) && grid_has(bits_q, hx, vy);

    item = '0;

    item[SLOT_CUR].present      = 1'b1;
    item[SLOT_CUR].pixel_x      = ax.pos0;
    item[SLOT_CUR].pixel_y      = ay.pos0;
    item[SLOT_CUR].span_columns = ax.span0;
    item[SLOT_CUR].span_rows    = ay.span0;
    item[SLOT_CUR].start_column = ax.start0;
    item[SLOT_CUR].start_row    = ay.start0;
    item[SLOT_CUR].chunk_x      = cx_q;
    item[SLOT_CUR].chunk_y      = cy_q;

    if (p1) begin
      item[SLOT_HORZ].present      = 1'b1;
      item[SLOT_HORZ].pixel_x      = ax.pos1;
      item[SLOT_HORZ].pixel_y      = ay.pos0;
      item[SLOT_HORZ].span_columns = ax.span1;
      item[SLOT_HORZ].span_rows    = ay.span0;
      item[SLOT_HORZ].start_column = ax.start1;
      item[SLOT_HORZ].start_row    = ay.start0;
      item[SLOT_HORZ].chunk_x      = ax.coord1;
      item[SLOT_HORZ].chunk_y      = cy_q;
    end

    if (p2) begin
      item[SLOT_VERT].present      = 1'b1;
      item[SLOT_VERT].pixel_x      = ax.pos0;
      item[SLOT_VERT].pixel_y      = ay.pos1;
      item[SLOT_VERT].span_columns = ax.span0;
      item[SLOT_VERT].span_rows    = ay.span1;
      item[SLOT_VERT].start_column = ax.start0;
      item[SLOT_VERT].start_row    = ay.start1;
      item[SLOT_VERT].chunk_x      = cx_q;
      item[SLOT_VERT].chunk_y      = ay.coord1;
    end

    if (p3) begin
      item[SLOT_DIAG].present      = 1'b1;
      item[SLOT_DIAG].pixel_x      = ax.pos1;
      item[SLOT_DIAG].pixel_y      = ay.pos1;
      item[SLOT_DIAG].span_columns = ax.span1;
      item[SLOT_DIAG].span_rows    = ay.span1;
      item[SLOT_DIAG].start_column = ax.start1;
      item[SLOT_DIAG].start_row    = ay.start1;
      item[SLOT_DIAG].chunk_x      = ax.coord1;
      item[SLOT_DIAG].chunk_y      = ay.coord1;
    end
  end

  tvcc_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (move),
    .item_i  (item),
    .free_o  (buf_free),
    .valid_o (valid_o),
    .slot_o  (slot),
    .res_o   (res)
  );

  assign slot_o         = slot;
  assign last_o         = (slot == SLOT_DIAG);
  assign present_o      = res.present;
  assign pixel_x_o      = res.pixel_x;
  assign pixel_y_o      = res.pixel_y;
  assign span_columns_o = res.span_columns;
  assign span_rows_o    = res.span_rows;
  assign start_column_o = res.start_column;
  assign start_row_o    = res.start_row;
  assign out_chunk_x_o  = res.chunk_x;
  assign out_chunk_y_o  = res.chunk_y;

`ifndef SYNTHESIS
  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && slot_o == $past(slot_o) + 2'd1))
    else $error("slot beats out of order");

  a_first_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (slot_o == SLOT_CUR))
    else $error("beat stream does not open on the current chunk");

  a_cur_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && slot_o == SLOT_CUR) |-> present_o)
    else $error("current chunk beat not present");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !move) |=> in_vld_q)
    else $error("pending item lost");
`endif

endmodule

// File: dv/tile_viewport_chunk_clipper_top_tb.sv
// Self-checking testbench for the viewport chunk clipper: predicted slot beats vs. DUT output.
module tile_viewport_chunk_clipper_top_tb;
  import tvcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_SIZE   = 32;
  localparam int TAIL_CYCLES = 6;
  localparam int DRAIN_LIMIT = 2000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0]         rel_column;
    logic [7:0]         rel_row;
    logic [1:0]         focus_x;
    logic [1:0]         focus_y;
    logic signed [15:0] chunk_x;
    logic signed [15:0] chunk_y;
    logic [8:0]         neighbor_present;
  } view_item_t;

  typedef struct packed {
    slot_e slot;
    res_t  body;
    logic  last;
  } slot_beat_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [7:0]         rel_column_i = '0;
  logic [7:0]         rel_row_i = '0;
  logic [1:0]         focus_x_i = '0;
  logic [1:0]         focus_y_i = '0;
  logic signed [15:0] chunk_x_i = '0;
  logic signed [15:0] chunk_y_i = '0;
  logic [8:0]         neighbor_present_i = '0;
  logic               valid_o;
  logic [1:0]         slot_o;
  logic               present_o;
  logic signed [15:0] pixel_x_o;
  logic signed [15:0] pixel_y_o;
  logic [8:0]         span_columns_o;
  logic [8:0]         span_rows_o;
  logic [7:0]         start_column_o;
  logic [7:0]         start_row_o;
  logic signed [15:0] out_chunk_x_o;
  logic signed [15:0] out_chunk_y_o;
  logic               last_o;

  logic [7:0] geometry [8];
  slot_beat_t expected_beats [$];
  int errors = 0;
  int beats_checked = 0;
  int items_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  tile_viewport_chunk_clipper_top #(
    .TILE_SIZE(TILE_SIZE)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .start_i(start_i),
    .busy_o(busy_o),
    .rel_column_i(rel_column_i),
    .rel_row_i(rel_row_i),
    .focus_x_i(focus_x_i),
    .focus_y_i(focus_y_i),
    .chunk_x_i(chunk_x_i),
    .chunk_y_i(chunk_y_i),
    .neighbor_present_i(neighbor_present_i),
    .valid_o(valid_o),
    .slot_o(slot_o),
    .present_o(present_o),
    .pixel_x_o(pixel_x_o),
    .pixel_y_o(pixel_y_o),
    .span_columns_o(span_columns_o),
    .span_rows_o(span_rows_o),
    .start_column_o(start_column_o),
    .start_row_o(start_row_o),
    .out_chunk_x_o(out_chunk_x_o),
    .out_chunk_y_o(out_chunk_y_o),
    .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic int clip0(int v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic bit grid_bit(logic [8:0] bits, int x, int y);
    if (x < 0 || x > 2 || y < 0 || y > 2) return 1'b0;
    return bits[x * 3 + y];
  endfunction

  function automatic slot_beat_t make_beat(slot_e s, bit pres, int px, int py, int across,
                                           int down, int sc, int sr, int ccx, int ccy);
    slot_beat_t b;
    b.slot = s;
    b.last = (s == SLOT_DIAG);
    b.body = '0;
    if (pres) begin
      if (across > int'(geometry[CFG_CHUNK_COLS])) across = int'(geometry[CFG_CHUNK_COLS]);
      if (down > int'(geometry[CFG_CHUNK_ROWS])) down = int'(geometry[CFG_CHUNK_ROWS]);
      b.body.present      = 1'b1;
      b.body.pixel_x      = 16'(px);
      b.body.pixel_y      = 16'(py);
      b.body.span_columns = 9'(clip0(across));
      b.body.span_rows    = 9'(clip0(down));
      b.body.start_column = 8'(clip0(sc));
      b.body.start_row    = 8'(clip0(sr));
      b.body.chunk_x      = 16'(ccx);
      b.body.chunk_y      = 16'(ccy);
    end
    return b;
  endfunction

  function automatic void split_viewport(view_item_t it);
    int org, cc, cr, cx, cy;
    int px0, py0, ac0, dn0, sc0, sr0, hd, vd;
    int px1, ac1, sc1, py2, dn2, sr2, e, room, lim;
    bit p1, p2, p3;
    org = -2 * TILE_SIZE;
    cc  = int'(geometry[CFG_CHUNK_COLS]);
    cr  = int'(geometry[CFG_CHUNK_ROWS]);
    cx  = int'(it.chunk_x);
    cy  = int'(it.chunk_y);
    px0 = org;
    py0 = org;
    ac0 = int'(geometry[CFG_WIN_COLS]) + 4;
    dn0 = int'(geometry[CFG_WIN_ROWS]) + 4;
    hd = 0; vd = 0;
    px1 = 0; ac1 = 0; sc1 = 0;
    py2 = 0; dn2 = 0; sr2 = 0;

    e = int'(it.rel_column) - int'(geometry[CFG_PLR_COL]) - 2;
    if (e < 0) begin
      px0 += TILE_SIZE * (-e);
      ac0 = clip0(ac0 + e);
      sc0 = 0;
      hd  = -1;
      px1 = org;
      ac1 = -e;
      sc1 = clip0(cc + e);
    end else begin
      sc0  = e;
      room = cc - int'(it.rel_column) - 1;
      lim  = int'(geometry[CFG_PLR_RIGHT]) + 2;
      if (room < lim) begin
        ac0 = clip0(ac0 - (lim - room));
        hd  = 1;
        px1 = px0 + TILE_SIZE * ac0;
        ac1 = lim - room;
        sc1 = 0;
      end
    end

    e = int'(it.rel_row) - int'(geometry[CFG_PLR_ROW]) - 2;
    if (e < 0) begin
      py0 += TILE_SIZE * (-e);
      dn0 = clip0(dn0 + e);
      sr0 = 0;
      vd  = -1;
      py2 = org;
      dn2 = -e;
      sr2 = clip0(cr + e);
    end else begin
      sr0  = e;
      room = cr - int'(it.rel_row) - 1;
      lim  = int'(geometry[CFG_PLR_BELOW]) + 2;
      if (room < lim) begin
        dn0 = clip0(dn0 - (lim - room));
        vd  = 1;
        py2 = py0 + TILE_SIZE * dn0;
        dn2 = lim - room;
        sr2 = 0;
      end
    end

    p1 = hd != 0 && grid_bit(it.neighbor_present, int'(it.focus_x) + hd, int'(it.focus_y));
    p2 = vd != 0 && grid_bit(it.neighbor_present, int'(it.focus_x), int'(it.focus_y) + vd);
    p3 = hd != 0 && vd != 0 &&
         grid_bit(it.neighbor_present, int'(it.focus_x) + hd, int'(it.focus_y) + vd);

    expected_beats.push_back(make_beat(SLOT_CUR, 1'b1, px0, py0, ac0, dn0, sc0, sr0, cx, cy));
    expected_beats.push_back(make_beat(SLOT_HORZ, p1, px1, py0, ac1, dn0, sc1, sr0,
                                       cx + hd, cy));
    expected_beats.push_back(make_beat(SLOT_VERT, p2, px0, py2, ac0, dn2, sc0, sr2,
                                       cx, cy + vd));
    expected_beats.push_back(make_beat(SLOT_DIAG, p3, px1, py2, ac1, dn2, sc1, sr2,
                                       cx + hd, cy + vd));
  endfunction

  // ---------------- beat checker ----------------

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    slot_beat_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, slot %0d", $time, slot_o);
      end else begin
        want = expected_beats.pop_front();
        check_field("slot", want.slot, slot_o);
        check_field("present", want.body.present, present_o);
        check_field("pixel_x", want.body.pixel_x, pixel_x_o);
        check_field("pixel_y", want.body.pixel_y, pixel_y_o);
        check_field("span_columns", want.body.span_columns, span_columns_o);
        check_field("span_rows", want.body.span_rows, span_rows_o);
        check_field("start_column", want.body.start_column, start_column_o);
        check_field("start_row", want.body.start_row, start_row_o);
        check_field("out_chunk_x", want.body.chunk_x, out_chunk_x_o);
        check_field("out_chunk_y", want.body.chunk_y, out_chunk_y_o);
        check_field("last", want.last, last_o);
        beats_checked++;
      end
    end
  end

  // ---------------- drivers ----------------

  task automatic send_item(input view_item_t it);
    start_i            <= 1'b1;
    rel_column_i       <= it.rel_column;
    rel_row_i          <= it.rel_row;
    focus_x_i          <= it.focus_x;
    focus_y_i          <= it.focus_y;
    chunk_x_i          <= it.chunk_x;
    chunk_y_i          <= it.chunk_y;
    neighbor_present_i <= it.neighbor_present;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    split_viewport(it);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    start_i <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_beats.size() != 0; n++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic sender_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    geometry[idx] = value;
  endtask

  task automatic program_geometry(input logic [7:0] win_cols, win_rows, plr_col, plr_row,
                                  plr_right, plr_below, chunk_cols, chunk_rows);
    pause_until_drained();
    write_reg(CFG_WIN_COLS, win_cols);
    write_reg(CFG_WIN_ROWS, win_rows);
    write_reg(CFG_PLR_COL, plr_col);
    write_reg(CFG_PLR_ROW, plr_row);
    write_reg(CFG_PLR_RIGHT, plr_right);
    write_reg(CFG_PLR_BELOW, plr_below);
    write_reg(CFG_CHUNK_COLS, chunk_cols);
    write_reg(CFG_CHUNK_ROWS, chunk_rows);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic view_item_t make_item(int rc, int rr, int fx, int fy, int cx, int cy,
                                           int bits);
    view_item_t it;
    it.rel_column       = 8'(rc);
    it.rel_row          = 8'(rr);
    it.focus_x          = 2'(fx);
    it.focus_y          = 2'(fy);
    it.chunk_x          = 16'(cx);
    it.chunk_y          = 16'(cy);
    it.neighbor_present = 9'(bits);
    return it;
  endfunction

  function automatic logic [7:0] pick_reg(int lo, int hi, int typical_hi);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'(lo);
    if (r < 16) return 8'(hi);
    return 8'($urandom_range(lo, typical_hi));
  endfunction

  function automatic logic [7:0] pick_rel(int size);
    if ($urandom_range(99) < 15) return 8'($urandom_range(0, 254));
    return 8'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'h7fff;
    if (r < 10) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic view_item_t random_item();
    view_item_t it;
    it.rel_column       = pick_rel(int'(geometry[CFG_CHUNK_COLS]));
    it.rel_row          = pick_rel(int'(geometry[CFG_CHUNK_ROWS]));
    it.focus_x          = 2'($urandom_range(0, 2));
    it.focus_y          = 2'($urandom_range(0, 2));
    it.chunk_x          = pick_coord();
    it.chunk_y          = pick_coord();
    it.neighbor_present = 9'($urandom_range(0, 511));
    return it;
  endfunction

  // ---------------- tests ----------------

  // reset geometry: 32x32 chunks, left edge at rel-12, right overflow past rel 20
  task automatic test_default_geometry();
    send_item(make_item(16, 16, 1, 1, 5, -5, 'h1ff));
    send_item(make_item(0, 0, 1, 1, 100, 200, 'h1ff));
    send_item(make_item(31, 31, 1, 1, -100, -200, 'h1ff));
    send_item(make_item(0, 31, 0, 2, 1, 1, 'h1ff));
    send_item(make_item(31, 0, 2, 0, 1, 1, 'h1ff));
    send_item(make_item(0, 0, 1, 1, 1, 1, 'h000));
    send_item(make_item(31, 31, 1, 1, 7, 7, 'h100));
    send_item(make_item(254, 254, 1, 1, 32767, -32768, 'h1ff));
    send_item(make_item(0, 0, 1, 1, -32768, -32768, 'h1ff));
    send_item(make_item(12, 9, 2, 1, 3, 4, 'h0aa));
    send_item(make_item(11, 8, 1, 2, 3, 4, 'h155));
    send_item(make_item(20, 21, 0, 1, 0, 0, 'h1ff));
    send_item(make_item(21, 22, 1, 0, 0, 0, 'h1ff));
  endtask

  // register extremes: spans clamped to chunk, saturated spans and starts
  task automatic test_edge_geometry();
    program_geometry(255, 255, 254, 254, 254, 254, 255, 255);
    send_item(make_item(0, 0, 1, 1, 10, 10, 'h1ff));
    send_item(make_item(254, 254, 2, 2, -1, 0, 'h1ff));
    send_item(make_item(128, 64, 1, 1, 0, -1, 'h1ff));
    program_geometry(1, 1, 0, 0, 0, 0, 1, 1);
    send_item(make_item(0, 0, 1, 1, 0, 0, 'h1ff));
    send_item(make_item(2, 2, 1, 1, 0, 0, 'h1ff));
    send_item(make_item(254, 254, 0, 0, 32767, 32767, 'h1ff));
    send_item(make_item(3, 1, 1, 1, 2, 2, 'h1ff));
    program_geometry(255, 255, 0, 0, 254, 254, 1, 1);
    send_item(make_item(2, 2, 1, 1, 9, 9, 'h1ff));
    send_item(make_item(0, 1, 1, 1, 9, 9, 'h1ff));
    program_geometry(1, 1, 254, 254, 0, 0, 255, 255);
    send_item(make_item(0, 0, 1, 1, -7, 7, 'h1ff));
    send_item(make_item(254, 254, 1, 1, 7, -7, 'h1ff));
  endtask

  task automatic test_random_traffic(input int idle_pct);
    for (int blk = 0; blk < 4; blk++) begin
      program_geometry(pick_reg(1, 255, 40), pick_reg(1, 255, 30), pick_reg(0, 254, 20),
                       pick_reg(0, 254, 16), pick_reg(0, 254, 20), pick_reg(0, 254, 16),
                       pick_reg(1, 255, 48), pick_reg(1, 255, 48));
      for (int k = 0; k < 18; k++) begin
        sender_gap(idle_pct);
        // hold the sender until every beat is back
        if (k == 9) pause_until_drained();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    geometry[CFG_WIN_COLS]   = RST_WIN_COLS;
    geometry[CFG_WIN_ROWS]   = RST_WIN_ROWS;
    geometry[CFG_PLR_COL]    = RST_PLR_COL;
    geometry[CFG_PLR_ROW]    = RST_PLR_ROW;
    geometry[CFG_PLR_RIGHT]  = RST_PLR_RIGHT;
    geometry[CFG_PLR_BELOW]  = RST_PLR_BELOW;
    geometry[CFG_CHUNK_COLS] = RST_CHUNK_COLS;
    geometry[CFG_CHUNK_ROWS] = RST_CHUNK_ROWS;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_edge_geometry();
    test_random_traffic(8);
    test_random_traffic(53);
    test_random_traffic(0);

    pause_until_drained();
    if (expected_beats.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
    end
    $display("Covered %0d position updates (%0d slot beats) under %0d geometry settings",
             items_sent, beats_checked, settings_used + 1);
    $display("with directed edge cases, random traffic and varied start gaps.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: tile_viewport_chunk_clipper_top.f
hdl/tvcc_pkg.sv
hdl/tvcc_axis.sv
hdl/tvcc_emit.sv
hdl/tile_viewport_chunk_clipper_top.sv
dv/tile_viewport_chunk_clipper_top_tb.sv
